FILE: rtl/assert_macros.svh
// Assertion macros, included by fp64_remainder_fmod.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: rtl/fmod_pkg.sv
package fmod_pkg;

    localparam int SigW = 53;
    localparam int ExpW = 13;

    localparam logic [63:0] SignMask   = 64'h8000_0000_0000_0000;
    localparam logic [62:0] ExpMask    = 63'h7ff0_0000_0000_0000;
    localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DefaultNan = 64'h7ff8_0000_0000_0000;

    typedef struct packed {
        logic [63:0] x_bits;
        logic [63:0] y_bits;
    } t_in;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        domain_error;
    } t_out;

    // Commands from the sequencer to the shared datapath.
    localparam logic [2:0] OpHold  = 3'd0;
    localparam logic [2:0] OpLoad  = 3'd1;
    localparam logic [2:0] OpNormY = 3'd2;
    localparam logic [2:0] OpNormX = 3'd3;
    localparam logic [2:0] OpStep  = 3'd4;
    localparam logic [2:0] OpLast  = 3'd5;
    localparam logic [2:0] OpNormR = 3'd6;

    typedef struct packed {
        logic [2:0] op;
    } t_ctl;

    typedef struct packed {
        logic my_norm;
        logic mx_norm;
        logic diff_pos;
        logic rem_zero;
    } t_sts;

endpackage

FILE: rtl/fp64_remainder_fmod.sv
// Channel   Direction  Payload
// request   in         x_bits, y_bits   (i_in_valid / o_in_stall)
// result    out        result_bits, domain_error (o_out_valid / i_out_stall)
// Special cases: the result is valid in the cycle right after the accepting edge.
// General case: the result follows the steps ny, nx, diff and nr and a done step, where ny, nx
// are subnormal normalization shifts (up to 52), diff is the exponent difference
// (up to 2097, one shared subtractor step each) and nr the renormalization (up to 52).
// Reset clears the sequencer and the output valid; no request is taken
// while busy or while a result is still held.
`include "assert_macros.svh"
module fp64_remainder_fmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fmod_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fmod_pkg::t_out    o_out_data
);

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StNormY = 3'd1;
    localparam logic [2:0] StNormX = 3'd2;
    localparam logic [2:0] StLoop  = 3'd3;
    localparam logic [2:0] StNormR = 3'd4;
    localparam logic [2:0] StDone  = 3'd5;

    logic [2:0] r_state, n_state;
    fmod_pkg::t_in  r_req;
    fmod_pkg::t_out r_out, n_out;
    logic r_ovld, n_ovld;
    fmod_pkg::t_ctl ctl;
    fmod_pkg::t_sts sts;
    logic [63:0] packed_res;
    logic accept;
    logic [62:0] ax, ay;
    fmod_pkg::t_in req_mux;

    assign o_in_stall = (r_state != StIdle) || r_ovld;
    assign accept = i_in_valid && !o_in_stall;
    assign req_mux = accept ? i_in_data : r_req;
    assign ax = i_in_data.x_bits[62:0];
    assign ay = i_in_data.y_bits[62:0];

    fmod_dp u_dp (
        .i_clk    (i_clk),
        .i_req    (req_mux),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_packed (packed_res)
    );

    // Sequencer: classify at acceptance, then drive the shared unit.
    always_comb begin
        n_state = r_state;
        n_out = r_out;
        n_ovld = r_ovld && i_out_stall;
        ctl.op = fmod_pkg::OpHold;
        case (r_state)
            StIdle: begin
                if (accept) begin
                    n_out.domain_error = 1'b0;
                    if (ay == '0) begin
                        n_out.result_bits = fmod_pkg::DefaultNan;
                        n_out.domain_error = 1'b1;
                        n_ovld = 1'b1;
                    end else if (ax >= fmod_pkg::ExpMask || ay > fmod_pkg::ExpMask) begin
                        n_ovld = 1'b1;
                        if (ax > fmod_pkg::ExpMask) begin
                            n_out.result_bits = i_in_data.x_bits | fmod_pkg::QuietBit;
                        end else if (ay > fmod_pkg::ExpMask) begin
                            n_out.result_bits = i_in_data.y_bits | fmod_pkg::QuietBit;
                        end else begin
                            n_out.result_bits = fmod_pkg::DefaultNan;
                        end
                    end else if (ax < ay) begin
                        n_out.result_bits = i_in_data.x_bits;
                        n_ovld = 1'b1;
                    end else if (ax == ay) begin
                        n_out.result_bits = i_in_data.x_bits & fmod_pkg::SignMask;
                        n_ovld = 1'b1;
                    end else begin
                        ctl.op = fmod_pkg::OpLoad;
                        n_state = StNormY;
                    end
                end
            end
            StNormY: begin
                if (!sts.my_norm) begin
                    ctl.op = fmod_pkg::OpNormY;
                end else begin
                    n_state = StNormX;
                end
            end
            StNormX: begin
                if (!sts.mx_norm) begin
                    ctl.op = fmod_pkg::OpNormX;
                end else begin
                    n_state = StLoop;
                end
            end
            StLoop: begin
                if (sts.diff_pos) begin
                    ctl.op = fmod_pkg::OpStep;
                end else begin
                    ctl.op = fmod_pkg::OpLast;
                    n_state = StNormR;
                end
            end
            StNormR: begin
                if (!sts.rem_zero && !sts.mx_norm) begin
                    ctl.op = fmod_pkg::OpNormR;
                end else begin
                    n_state = StDone;
                end
            end
            StDone: begin
                n_out.result_bits = packed_res;
                n_out.domain_error = 1'b0;
                n_ovld = 1'b1;
                n_state = StIdle;
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_ovld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld <= n_ovld;
        end
        r_out <= n_out;
        if (accept) begin
            r_req <= i_in_data;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_data = r_out;

    `ASSERT_IMPL(a_busy_stalls, i_clk, i_rst_n, r_state != StIdle, o_in_stall)
    `ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == StDone, o_out_valid)
    `ASSERT_IMPL(a_no_valid_busy, i_clk, i_rst_n, r_state != StIdle, !o_out_valid)
    `ASSERT_IMPL(a_err_nan, i_clk, i_rst_n, o_out_valid && o_out_data.domain_error,
                 o_out_data.result_bits == fmod_pkg::DefaultNan)

endmodule

FILE: rtl/fmod_dp.sv
module fmod_dp (
    input  logic              i_clk,
    input  fmod_pkg::t_in     i_req,
    input  fmod_pkg::t_ctl    i_ctl,
    output fmod_pkg::t_sts    o_sts,
    output logic [63:0]       o_packed
);

    // The partial remainder needs one bit above the significand: after a step
    // it is below the divisor and is then doubled.
    logic [fmod_pkg::SigW:0] r_mx, n_mx;
    logic [fmod_pkg::SigW-1:0] r_my, n_my;
    logic signed [fmod_pkg::ExpW-1:0] r_ey, n_ey, r_diff, n_diff;
    logic [63:0] r_sx, n_sx;
    logic [fmod_pkg::SigW+1:0] sub;
    logic [10:0] ex_f, ey_f;
    logic [fmod_pkg::SigW:0] trial;
    logic [fmod_pkg::ExpW-1:0] sh;
    logic [fmod_pkg::SigW:0] shifted;

    assign ex_f = i_req.x_bits[62:52];
    assign ey_f = i_req.y_bits[62:52];

    // One shared subtractor serves the remainder loop.
    assign sub   = {1'b0, r_mx} - {2'b00, r_my};
    assign trial = sub[fmod_pkg::SigW+1] ? r_mx : sub[fmod_pkg::SigW:0];

    always_comb begin
        n_mx = r_mx;
        n_my = r_my;
        n_ey = r_ey;
        n_diff = r_diff;
        n_sx = r_sx;
        case (i_ctl.op)
            fmod_pkg::OpLoad: begin
                n_sx = i_req.x_bits & fmod_pkg::SignMask;
                n_mx = {1'b0, (ex_f != 11'd0), i_req.x_bits[51:0]};
                n_my = {(ey_f != 11'd0), i_req.y_bits[51:0]};
                n_ey = (ey_f == 11'd0) ? fmod_pkg::ExpW'(1)
                                       : fmod_pkg::ExpW'(ey_f);
                n_diff = fmod_pkg::ExpW'((ex_f == 11'd0) ? 11'd1 : ex_f)
                       - ((ey_f == 11'd0) ? fmod_pkg::ExpW'(1)
                                          : fmod_pkg::ExpW'(ey_f));
            end
            fmod_pkg::OpNormY: begin
                n_my = {r_my[fmod_pkg::SigW-2:0], 1'b0};
                n_ey = r_ey - 1'b1;
                n_diff = r_diff + 1'b1;
            end
            fmod_pkg::OpNormX: begin
                n_mx = {r_mx[fmod_pkg::SigW-1:0], 1'b0};
                n_diff = r_diff - 1'b1;
            end
            fmod_pkg::OpStep: begin
                n_mx = {trial[fmod_pkg::SigW-1:0], 1'b0};
                n_diff = r_diff - 1'b1;
            end
            fmod_pkg::OpLast: n_mx = trial;
            fmod_pkg::OpNormR: begin
                n_mx = {r_mx[fmod_pkg::SigW-1:0], 1'b0};
                n_ey = r_ey - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mx <= n_mx;
        r_my <= n_my;
        r_ey <= n_ey;
        r_diff <= n_diff;
        r_sx <= n_sx;
    end

    assign o_sts.my_norm  = r_my[fmod_pkg::SigW-1];
    assign o_sts.mx_norm  = r_mx[fmod_pkg::SigW-1];
    assign o_sts.diff_pos = (r_diff > 0);
    assign o_sts.rem_zero = (r_mx == '0);

    // Repack as zero, normal or subnormal; the shift is taken at most once.
    assign sh = fmod_pkg::ExpW'(1) - r_ey;
    assign shifted = (sh > fmod_pkg::ExpW'(63)) ? '0 : (r_mx >> sh);

    always_comb begin
        if (r_mx == '0) begin
            o_packed = r_sx;
        end else if (r_ey <= 0) begin
            o_packed = r_sx | 64'(shifted);
        end else begin
            o_packed = r_sx | {1'b0, r_ey[10:0], r_mx[51:0]};
        end
    end

endmodule

FILE: test/fp64_remainder_fmod_tb.sv
`timescale 1ns / 1ps
module fp64_remainder_fmod_tb;

    localparam int WatchLimit = 20000;
    localparam int DrainWait  = 2300;
    localparam logic [63:0] FracField = 64'h000f_ffff_ffff_ffff;
    localparam logic [63:0] HiddenOne = 64'h0010_0000_0000_0000;
    localparam logic [63:0] PosInf    = 64'h7ff0_0000_0000_0000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    fmod_pkg::t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    fmod_pkg::t_out o_out_data;

    fmod_pkg::t_out rem_expected_q[$];
    int   mismatch_count;
    int   idle_cycles = 0;
    bit   timed_out;
    bit   hold_off;
    bit   stall_enable;

    fp64_remainder_fmod DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Exact remainder of two binary64 patterns, sign taken from the dividend.
    function automatic fmod_pkg::t_out fmod_predict(logic [63:0] xb, logic [63:0] yb);
        fmod_pkg::t_out r;
        logic [63:0] sx;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] mx;
        logic [63:0] my;
        int          ey;
        int          ex;
        int          diff;
        int          sh;
        sx = xb & fmod_pkg::SignMask;
        ax = xb & ~fmod_pkg::SignMask;
        ay = yb & ~fmod_pkg::SignMask;
        r.domain_error = 1'b0;
        if (ay == 0) begin
            r.domain_error = 1'b1;
            r.result_bits  = fmod_pkg::DefaultNan;
            return r;
        end
        if (ax >= PosInf || ay > PosInf) begin
            if (ax > PosInf) r.result_bits = xb | fmod_pkg::QuietBit;
            else if (ay > PosInf) r.result_bits = yb | fmod_pkg::QuietBit;
            else r.result_bits = fmod_pkg::DefaultNan;
            return r;
        end
        if (ax < ay) begin
            r.result_bits = xb;
            return r;
        end
        if (ax == ay) begin
            r.result_bits = sx;
            return r;
        end
        ey = int'(ay >> 52);
        ex = int'(ax >> 52);
        mx = ax;
        my = ay;
        if (ey == 0) begin
            ey = 1;
            while (my < HiddenOne) begin
                ey--;
                my = my << 1;
            end
            diff = ex - ey;
            if (ex == 0) begin
                diff++;
                while (mx < HiddenOne) begin
                    diff--;
                    mx = mx << 1;
                end
            end else begin
                mx = HiddenOne | (mx & FracField);
            end
        end else begin
            diff = ex - ey;
            mx = HiddenOne | (mx & FracField);
            my = HiddenOne | (my & FracField);
        end
        while (diff > 0) begin
            if (mx >= my) mx = mx - my;
            mx = mx << 1;
            diff--;
        end
        if (mx >= my) mx = mx - my;
        if (mx == 0) begin
            r.result_bits = sx;
            return r;
        end
        while (mx < HiddenOne) begin
            mx = mx << 1;
            ey--;
        end
        if (ey <= 0) begin
            sh = 1 - ey;
            mx = (sh > 63) ? 64'd0 : (mx >> sh);
            r.result_bits = sx | mx;
        end else begin
            r.result_bits = sx | (64'(ey) << 52) | (mx & FracField);
        end
        return r;
    endfunction

    // Random operand with its exponent field drawn from [expo_lo, expo_hi].
    function automatic logic [63:0] rand_double(int expo_lo, int expo_hi);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v[62:52] = 11'($urandom_range(expo_hi, expo_lo));
        return v;
    endfunction

    // Offers one request and waits until it is taken.
    task automatic send_request(logic [63:0] xb, logic [63:0] yb);
        i_in_valid          <= 1'b1;
        i_in_data.x_bits    <= xb;
        i_in_data.y_bits    <= yb;
        rem_expected_q.push_back(fmod_predict(xb, yb));
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Random gap between bursts; valid drops only when a gap occurs.
    task automatic sender_gap();
        int gap;
        if ($urandom_range(3, 0) == 0) begin
            gap = $urandom_range(6, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (rem_expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [63:0] vals[$];
        vals = '{64'h0, fmod_pkg::SignMask, PosInf, PosInf | fmod_pkg::SignMask,
                 fmod_pkg::DefaultNan,
                 64'h7ff0_0000_0000_0001, 64'hfff4_0000_0000_0000, 64'h1,
                 64'h800f_ffff_ffff_ffff, 64'h0010_0000_0000_0000,
                 64'h7fef_ffff_ffff_ffff, 64'h3ff0_0000_0000_0000,
                 64'hc008_0000_0000_0000};
        // Zero divisor, NaNs, infinities, equal and smaller magnitudes.
        for (int k = 0; k < 5; k++) send_request(vals[k + 5], vals[k]);
        send_request(PosInf, 64'h3ff0_0000_0000_0000);
        send_request(64'h3ff0_0000_0000_0000, PosInf);
        send_request(64'h7ff0_0000_0000_0001, 64'h7ff0_0000_0000_0002);
        send_request(64'h3ff0_0000_0000_0000, 64'h7ff0_0000_0000_0002);
        send_request(64'hc008_0000_0000_0000, 64'h4008_0000_0000_0000);
        send_request(64'h3ff0_0000_0000_0000, 64'h4008_0000_0000_0000);
        send_request(64'hc008_0000_0000_0000, 64'h3ff0_0000_0000_0000);
        // Largest exponent spread and subnormal results.
        send_request(64'h7fef_ffff_ffff_ffff, 64'h1);
        send_request(64'hffef_ffff_ffff_ffff, 64'h0000_0000_0000_0003);
        send_request(64'h000f_ffff_ffff_ffff, 64'h0000_0000_0000_0007);
        send_request(64'h0010_0000_0000_0001, 64'h000f_ffff_ffff_ffff);
        send_request(64'h4010_0000_0000_0001, 64'h3ff8_0000_0000_0000);
        send_request(64'h7fef_ffff_ffff_ffff, 64'h000f_ffff_ffff_ffff);
        send_request(64'h0040_0000_0000_0001, 64'h0010_0000_0000_0000);
        send_request(64'hffff_ffff_ffff_ffff, 64'h0);
        wait_drained();
    endtask

    task automatic test_random(int n);
        logic [63:0] xb;
        logic [63:0] yb;
        int          sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(19, 0);
            if (sel == 0) begin
                // Rare wide spread, up to near the full loop length.
                xb = rand_double(1800, 2046);
                yb = rand_double(0, 200);
            end else if (sel < 3) begin
                xb = {$urandom, $urandom};
                yb = {$urandom, $urandom};
                if ($urandom_range(1, 0)) yb[62:52] = xb[62:52];
            end else if (sel < 5) begin
                // Special operands in either position.
                xb = rand_double(0, 2047);
                yb = rand_double(0, 2047);
                case ($urandom_range(3, 0))
                    0: yb[62:0] = 63'h0;
                    1: xb[62:52] = 11'h7ff;
                    2: yb[62:52] = 11'h7ff;
                    default: xb[62:0] = 63'h0;
                endcase
            end else begin
                xb = rand_double(0, 1100);
                yb = rand_double(0, 1100);
                xb[62:52] = 11'($urandom_range(2046, 0));
                if (xb[62:52] > 60) yb[62:52] = xb[62:52] - 11'($urandom_range(60, 0));
            end
            send_request(xb, yb);
            sender_gap();
        end
    endtask

    // Receiver held off while the sender keeps offering requests.
    task automatic test_backpressure();
        hold_off <= 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            test_random(6);
        join
        wait_drained();
    endtask

    // Result check against the oldest expectation.
    always @(posedge i_clk) begin
        fmod_pkg::t_out exp_out;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rem_expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h %b", o_out_data.result_bits,
                             o_out_data.domain_error);
            end else begin
                exp_out = rem_expected_q.pop_front();
                if (o_out_data.result_bits !== exp_out.result_bits ||
                    o_out_data.domain_error !== exp_out.domain_error) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h %b, got %h %b",
                                 exp_out.result_bits, exp_out.domain_error,
                                 o_out_data.result_bits, o_out_data.domain_error);
                end
            end
        end
    end

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else if (!stall_enable) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(3, 0) == 0);
    end

    // Watchdog on cycles with no accepted request or result.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_in_data      <= '0;
        hold_off       <= 1'b0;
        stall_enable   = 1'b0;
        mismatch_count = 0;
        timed_out      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        stall_enable = 1'b1;
        test_backpressure();
        test_random(130);
        wait_drained();
        stall_enable = 1'b0;
        test_random(130);
        wait_drained();
        repeat (DrainWait) @(posedge i_clk);
        if (mismatch_count == 0 && rem_expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
